[src/ewfp_pkg.sv]
`timescale 1ns / 1ps

package ewfp_pkg;

   // fixed-point layout
   localparam int FRAC_BITS      = 16;
   localparam int MAX_FILL_STEPS = 1024;
   localparam int STEP_W         = $clog2(MAX_FILL_STEPS + 1);
   localparam int AVG_W          = 28;
   localparam int SCORE_W        = 48;
   localparam int Q_SHIFT        = 16;
   localparam int RATIO_SHIFT    = FRAC_BITS + 8;
   localparam int UP_SHIFT       = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int DOWN_SHIFT     = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
   localparam int NEG_LEVEL_INT  = ((1 << FRAC_BITS) + 5) / 10;
   localparam logic [AVG_W-1:0] NEG_LEVEL = AVG_W'(NEG_LEVEL_INT);
   localparam logic [33:0] GAP_SLACK_MS = 34'd100;

   // shared multiplier: 48-bit operands, one 16-bit digit of b per cycle
   localparam int OPND_W    = 48;
   localparam int DIGIT_W   = 16;
   localparam int PART_W    = OPND_W + DIGIT_W;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int DIG_CNT_W = $clog2(OPND_W / DIGIT_W + 1);

   // request fields
   localparam int OP_W    = 2;
   localparam int TIME_W  = 32;
   localparam int WATTS_W = 12;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [OP_W-1:0] {
      OP_START  = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_FINISH = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      REG_INTERVAL   = 3'd0,
      REG_DECAY      = 3'd1,
      REG_NEW_WEIGHT = 3'd2,
      REG_POINTS     = 3'd3,
      REG_INV_THRESH = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [15:0] interval_ms;
      logic [15:0] decay_q16;
      logic [15:0] new_weight_q16;
      logic [23:0] points_per_interval_q16;
      logic [23:0] inverse_threshold_q24;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [OPND_W-1:0]    a;
      logic [OPND_W-1:0]    b;
      logic [DIG_CNT_W-1:0] digits;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] product;
   } mul_rsp_type;

   // product >> 16, clipped to 48 bits
   function automatic logic [SCORE_W-1:0] sat_q16(input logic [PROD_W-1:0] p);
      logic clip;
      clip = |p[PROD_W-1:Q_SHIFT+SCORE_W];
      return clip ? {SCORE_W{1'b1}} : p[Q_SHIFT +: SCORE_W];
   endfunction

   function automatic logic clip_q16(input logic [PROD_W-1:0] p);
      return |p[PROD_W-1:Q_SHIFT+SCORE_W];
   endfunction

endpackage

[src/ewfp_if.sv]
`timescale 1ns / 1ps

interface ewfp_req_if import ewfp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [TIME_W-1:0]  sample_time_ms;
   logic [WATTS_W-1:0] sample_watts;

   modport source (output valid, output operation, output sample_time_ms,
                   output sample_watts, input ready);
   modport sink   (input valid, input operation, input sample_time_ms,
                   input sample_watts, output ready);
endinterface

interface ewfp_rsp_if import ewfp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SCORE_W-1:0] score_q16;
   logic [AVG_W-1:0]   average_power_q16;
   logic               saturated;

   modport source (output valid, output score_q16, output average_power_q16,
                   output saturated, input ready);
   modport sink   (input valid, input score_q16, input average_power_q16,
                   input saturated, output ready);
endinterface

[src/ewfp_mul.sv]
`timescale 1ns / 1ps

module ewfp_mul import ewfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   logic [OPND_W-1:0]    a_ff, a_in;
   logic [OPND_W-1:0]    b_ff, b_in;
   logic [DIG_CNT_W-1:0] dig_ff, dig_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;

   logic [DIGIT_W-1:0]   digit;
   logic [PART_W-1:0]    partial;
   logic [PROD_W-1:0]    prod_next;

   // most significant digit first: prod = prod * 2^16 + a * digit
   always_comb begin
      digit     = b_ff[dig_ff*DIGIT_W +: DIGIT_W];
      partial   = PART_W'(a_ff) * PART_W'(digit);
      prod_next = {prod_ff[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
                + {{(PROD_W-PART_W){1'b0}}, partial};
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      dig_in  = dig_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      prod_in = prod_ff;
      if (req.start) begin
         a_in    = req.a;
         b_in    = req.b;
         dig_in  = req.digits - DIG_CNT_W'(1);
         run_in  = 1'b1;
         prod_in = '0;
      end else if (run_ff) begin
         prod_in = prod_next;
         if (dig_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            dig_in = dig_ff - DIG_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      dig_ff  <= dig_in;
      prod_ff <= prod_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.product = prod_ff;

endmodule

[src/ewfp_csr.sv]
`timescale 1ns / 1ps

module ewfp_csr import ewfp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] index;

   assign index      = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_INTERVAL:   cfg_in.interval_ms             = csr_pwdata[15:0];
            REG_DECAY:      cfg_in.decay_q16               = csr_pwdata[15:0];
            REG_NEW_WEIGHT: cfg_in.new_weight_q16          = csr_pwdata[15:0];
            REG_POINTS:     cfg_in.points_per_interval_q16 = csr_pwdata[23:0];
            REG_INV_THRESH: cfg_in.inverse_threshold_q24   = csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_INTERVAL:   csr_prdata = {16'd0, cfg_ff.interval_ms};
         REG_DECAY:      csr_prdata = {16'd0, cfg_ff.decay_q16};
         REG_NEW_WEIGHT: csr_prdata = {16'd0, cfg_ff.new_weight_q16};
         REG_POINTS:     csr_prdata = {8'd0, cfg_ff.points_per_interval_q16};
         REG_INV_THRESH: csr_prdata = {8'd0, cfg_ff.inverse_threshold_q24};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_ms             <= 16'd1000;
         cfg_ff.decay_q16               <= 16'd63015;
         cfg_ff.new_weight_q16          <= 16'd2521;
         cfg_ff.points_per_interval_q16 <= 24'd1820;
         cfg_ff.inverse_threshold_q24   <= 24'd67109;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/ewfp_seq.sv]
`timescale 1ns / 1ps

module ewfp_seq import ewfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   ewfp_req_if.sink    req_ch,
   ewfp_rsp_if.source  rsp_ch,
   output mul_req_type mreq,
   input  mul_rsp_type mrsp
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DECAY,
      ST_DECAY_WAIT,
      ST_TERM,
      ST_TERM_WAIT,
      ST_RATIO,
      ST_RATIO_WAIT,
      ST_R2,
      ST_R2_WAIT,
      ST_R4,
      ST_R4_WAIT,
      ST_PTS,
      ST_PTS_WAIT,
      ST_ACC,
      ST_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [WATTS_W-1:0] watts_ff, watts_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic               own_ff, own_in;
   logic [AVG_W-1:0]   w_ff, w_in;
   logic [TIME_W-1:0]  last_ff, last_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic               ovf_ff, ovf_in;
   logic [OPND_W-1:0]  tmp_ff, tmp_in;
   mul_req_type        mreq_ff, mreq_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic [AVG_W-1:0]   rsp_avg_ff, rsp_avg_in;
   logic               rsp_sat_ff, rsp_sat_in;

   logic [33:0]        gap_limit;
   logic               gap_open;
   logic               fill_more;
   logic [63:0]        term;
   logic [64:0]        avg_sum;
   logic [SCORE_W:0]   acc_sum;

   always_comb begin
      gap_limit = {2'b0, last_ff} + {18'b0, cfg.interval_ms} + GAP_SLACK_MS;
      gap_open  = ({2'b0, time_ff} > gap_limit) || (op_ff == OP_FINISH);
      fill_more = (steps_ff < STEP_W'(MAX_FILL_STEPS)) && (w_ff > NEG_LEVEL) && gap_open;
      term      = (mrsp.product[63:0] << UP_SHIFT) >> DOWN_SHIFT;
      avg_sum   = {{(65-AVG_W){1'b0}}, w_ff} + {1'b0, term};
      acc_sum   = {1'b0, score_ff} + {1'b0, tmp_ff};
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      time_in      = time_ff;
      watts_in     = watts_ff;
      steps_in     = steps_ff;
      own_in       = own_ff;
      w_in         = w_ff;
      last_in      = last_ff;
      score_in     = score_ff;
      ovf_in       = ovf_ff;
      tmp_in       = tmp_ff;
      mreq_in      = mreq_ff;
      mreq_in.start = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_score_in = rsp_score_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_sat_in   = rsp_sat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.operation;
               time_in  = req_ch.sample_time_ms;
               watts_in = req_ch.sample_watts;
               steps_in = '0;
               case (req_ch.operation)
                  OP_START: begin
                     w_in     = '0;
                     last_in  = '0;
                     score_in = '0;
                     ovf_in   = 1'b0;
                     state_in = ST_OUT;
                  end
                  OP_SAMPLE, OP_FINISH: state_in = ST_CHECK;
                  default:              state_in = ST_OUT;
               endcase
            end
         end
         ST_CHECK: begin
            if (fill_more) begin
               own_in   = 1'b0;
               state_in = ST_DECAY;
            end else if (op_ff == OP_SAMPLE) begin
               own_in   = 1'b1;
               state_in = ST_DECAY;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_DECAY: begin
            mreq_in.start  = 1'b1;
            mreq_in.a      = {{(OPND_W-AVG_W){1'b0}}, w_ff};
            mreq_in.b      = {{(OPND_W-16){1'b0}}, cfg.decay_q16};
            mreq_in.digits = DIG_CNT_W'(1);
            state_in       = ST_DECAY_WAIT;
         end
         ST_DECAY_WAIT: begin
            if (mrsp.done) begin
               w_in = mrsp.product[Q_SHIFT +: AVG_W];
               if (own_ff) begin
                  state_in = ST_TERM;
               end else begin
                  last_in  = last_ff + {16'b0, cfg.interval_ms};
                  steps_in = steps_ff + STEP_W'(1);
                  state_in = ST_RATIO;
               end
            end
         end
         ST_TERM: begin
            mreq_in.start  = 1'b1;
            mreq_in.a      = {{(OPND_W-16){1'b0}}, cfg.new_weight_q16};
            mreq_in.b      = {{(OPND_W-WATTS_W){1'b0}}, watts_ff};
            mreq_in.digits = DIG_CNT_W'(1);
            state_in       = ST_TERM_WAIT;
         end
         ST_TERM_WAIT: begin
            if (mrsp.done) begin
               w_in     = (|avg_sum[64:AVG_W]) ? {AVG_W{1'b1}} : avg_sum[AVG_W-1:0];
               last_in  = time_ff;
               state_in = ST_RATIO;
            end
         end
         ST_RATIO: begin
            mreq_in.start  = 1'b1;
            mreq_in.a      = {{(OPND_W-AVG_W){1'b0}}, w_ff};
            mreq_in.b      = {{(OPND_W-24){1'b0}}, cfg.inverse_threshold_q24};
            mreq_in.digits = DIG_CNT_W'(2);
            state_in       = ST_RATIO_WAIT;
         end
         ST_RATIO_WAIT: begin
            if (mrsp.done) begin
               tmp_in   = mrsp.product[RATIO_SHIFT +: OPND_W];
               state_in = ST_R2;
            end
         end
         ST_R2: begin
            mreq_in.start  = 1'b1;
            mreq_in.a      = tmp_ff;
            mreq_in.b      = tmp_ff;
            mreq_in.digits = DIG_CNT_W'(3);
            state_in       = ST_R2_WAIT;
         end
         ST_R2_WAIT: begin
            if (mrsp.done) begin
               tmp_in   = sat_q16(mrsp.product);
               ovf_in   = ovf_ff | clip_q16(mrsp.product);
               state_in = ST_R4;
            end
         end
         ST_R4: begin
            mreq_in.start  = 1'b1;
            mreq_in.a      = tmp_ff;
            mreq_in.b      = tmp_ff;
            mreq_in.digits = DIG_CNT_W'(3);
            state_in       = ST_R4_WAIT;
         end
         ST_R4_WAIT: begin
            if (mrsp.done) begin
               tmp_in   = sat_q16(mrsp.product);
               ovf_in   = ovf_ff | clip_q16(mrsp.product);
               state_in = ST_PTS;
            end
         end
         ST_PTS: begin
            mreq_in.start  = 1'b1;
            mreq_in.a      = tmp_ff;
            mreq_in.b      = {{(OPND_W-24){1'b0}}, cfg.points_per_interval_q16};
            mreq_in.digits = DIG_CNT_W'(2);
            state_in       = ST_PTS_WAIT;
         end
         ST_PTS_WAIT: begin
            if (mrsp.done) begin
               tmp_in   = sat_q16(mrsp.product);
               ovf_in   = ovf_ff | clip_q16(mrsp.product);
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (acc_sum[SCORE_W]) begin
               score_in = {SCORE_W{1'b1}};
               ovf_in   = 1'b1;
            end else begin
               score_in = acc_sum[SCORE_W-1:0];
            end
            // the sample's own interval ends the request; gap steps loop back
            state_in = own_ff ? ST_OUT : ST_CHECK;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_score_in = score_ff;
               rsp_avg_in   = w_ff;
               rsp_sat_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      time_ff      <= time_in;
      watts_ff     <= watts_in;
      steps_ff     <= steps_in;
      own_ff       <= own_in;
      tmp_ff       <= tmp_in;
      mreq_ff      <= mreq_in;
      rsp_score_ff <= rsp_score_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_sat_ff   <= rsp_sat_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         w_ff          <= '0;
         last_ff       <= '0;
         score_ff      <= '0;
         ovf_ff        <= 1'b0;
         mreq_ff.start <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         w_ff         <= w_in;
         last_ff      <= last_in;
         score_ff     <= score_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign mreq                     = mreq_ff;
   assign req_ch.ready             = (state_ff == ST_IDLE);
   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.score_q16         = rsp_score_ff;
   assign rsp_ch.average_power_q16 = rsp_avg_ff;
   assign rsp_ch.saturated         = rsp_sat_ff;

endmodule

[src/ewma_fourth_power_score_core.sv]
`timescale 1ns / 1ps

// Weighted fourth-power score engine. Each request (start, sample or finish)
// yields exactly one response holding the score, the weighted average power
// and the sticky saturation flag. All arithmetic runs through one shared
// 48x16 multiplier that takes one 16-bit digit of its second operand per
// cycle; the sequencer steps through decay, the new-sample term (a sample's own
// interval only), ratio, square, fourth power and points in turn. Every gap or
// tail interval filled runs these steps again, up to 1024 intervals per
// request. A request is taken only while the sequencer is idle; a finished
// response sits in an output register, so the next request can be taken
// before it is collected.
module ewma_fourth_power_score_core import ewfp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ewfp_req_if.sink              req_ch,
   ewfp_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type     cfg;
   mul_req_type mreq;
   mul_rsp_type mrsp;

   ewfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ewfp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   ewfp_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .mreq   (mreq),
      .mrsp   (mrsp)
   );

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench import ewfp_pkg::*; ();

   localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
   localparam logic [63:0]     SCORE_LIMIT = 64'hFFFF_FFFF_FFFF;
   localparam logic [27:0]     AVG_LIMIT   = 28'hFFF_FFFF;
   localparam int              FILL_LIMIT  = 1024;
   // 0.1 W with 16 fraction bits, rounded to nearest
   localparam logic [27:0]     NEGLIGIBLE  = 28'd6554;
   localparam int unsigned     LONG_HOLD   = 300;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [AVG_W-1:0]   average;
      logic               saturated;
   } score_report_type;

   class ride_score_tracker;
      logic [15:0]      interval      = 16'd1000;
      logic [15:0]      decay         = 16'd63015;
      logic [15:0]      new_weight    = 16'd2521;
      logic [23:0]      points_rate   = 24'd1820;
      logic [23:0]      inv_threshold = 24'd67109;
      logic [27:0]      power         = '0;
      logic [31:0]      last_stamp    = '0;
      logic [47:0]      score         = '0;
      logic             sticky        = 1'b0;
      bit               clip_now;
      score_report_type due_reports[$];
      int unsigned      failures      = 0;

      function void set_register(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_INTERVAL:   interval      = value[15:0];
            REG_DECAY:      decay         = value[15:0];
            REG_NEW_WEIGHT: new_weight    = value[15:0];
            REG_POINTS:     points_rate   = value[23:0];
            REG_INV_THRESH: inv_threshold = value[23:0];
            default: ;
         endcase
      endfunction

      // (a * b) >> 16, clipped at the score limit
      function logic [63:0] q16_mul(logic [63:0] a, logic [63:0] b);
         logic [127:0] full;
         full = ({64'd0, a} * {64'd0, b}) >> 16;
         if (full > SCORE_LIMIT) begin
            clip_now = 1'b1;
            return SCORE_LIMIT;
         end
         return full[63:0];
      endfunction

      function void add_interval_points();
         logic [63:0] ratio, sq, quad, pts;
         logic [64:0] total;
         clip_now = 1'b0;
         ratio = (64'(power) * 64'(inv_threshold)) >> 24;
         sq    = q16_mul(ratio, ratio);
         quad  = q16_mul(sq, sq);
         pts   = q16_mul(64'(points_rate), quad);
         total = 65'(score) + 65'(pts);
         if (total > 65'(SCORE_LIMIT)) begin
            total    = 65'(SCORE_LIMIT);
            clip_now = 1'b1;
         end
         score = total[47:0];
         if (clip_now)
            sticky = 1'b1;
      endfunction

      function void decay_interval();
         power      = 28'((64'(power) * 64'(decay)) >> 16);
         last_stamp = last_stamp + interval;
         add_interval_points();
      endfunction

      function void take_request(logic [1:0] op, logic [31:0] stamp, logic [11:0] watts);
         int          steps;
         logic [63:0] level;
         steps = 0;
         if (op == OP_START) begin
            power      = '0;
            last_stamp = '0;
            score      = '0;
            sticky     = 1'b0;
         end else if (op == OP_SAMPLE) begin
            // fill the gap one interval at a time
            while (steps < FILL_LIMIT && power > NEGLIGIBLE &&
                   {32'd0, stamp} > {32'd0, last_stamp} + 64'(interval) + 64'd100) begin
               decay_interval();
               steps++;
            end
            level = ((64'(power) * 64'(decay)) >> 16) + 64'(new_weight) * 64'(watts);
            power = (level > 64'(AVG_LIMIT)) ? AVG_LIMIT : level[27:0];
            last_stamp = stamp;
            add_interval_points();
         end else if (op == OP_FINISH) begin
            while (steps < FILL_LIMIT && power > NEGLIGIBLE) begin
               decay_interval();
               steps++;
            end
         end
         due_reports.push_back(score_report_type'{score: score, average: power,
                                                  saturated: sticky});
      endfunction

      function void flag_field(string field, logic [63:0] want, logic [63:0] got);
         failures++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      endfunction

      function void check_response(logic [47:0] got_score, logic [27:0] got_avg,
                                   logic got_sat);
         score_report_type want;
         if (due_reports.size() == 0) begin
            failures++;
            $display("%0t: response with nothing expected, expected none, got score %0h",
                     $time, got_score);
            return;
         end
         want = due_reports.pop_front();
         if (got_score !== want.score)
            flag_field("score_q16", 64'(want.score), 64'(got_score));
         if (got_avg !== want.average)
            flag_field("average_power_q16", 64'(want.average), 64'(got_avg));
         if (got_sat !== want.saturated)
            flag_field("saturated", 64'(want.saturated), 64'(got_sat));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ewfp_req_if req_bus ();
   ewfp_rsp_if rsp_bus ();

   ride_score_tracker tracker;
   bit                out_of_reset  = 1'b0;
   bit                hold_request  = 1'b0;
   int unsigned       snd_max_gap   = 0;
   int unsigned       rcv_max_gap   = 0;
   int unsigned       requests_sent = 0;

   ewma_fourth_power_score_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [31:0] pick_setting(logic [31:0] usual, logic [31:0] lo,
                                                logic [31:0] hi);
      case ($urandom_range(0, 3))
         0: return usual;
         1: return lo;
         2: return hi;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_register(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_request(logic [1:0] op, logic [31:0] stamp, logic [11:0] watts);
      int unsigned pause;
      pause = $urandom_range(0, snd_max_gap);
      @(negedge clock);
      if (pause != 0) begin
         req_bus.valid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.operation      <= op;
      req_bus.sample_time_ms <= stamp;
      req_bus.sample_watts   <= watts;
      do @(posedge clock); while (!req_bus.ready);
      tracker.take_request(op, stamp, watts);
      requests_sent++;
   endtask

   // block is idle once every response has come back
   task automatic end_phase();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (tracker.due_reports.size() != 0)
         @(posedge clock);
   endtask

   task automatic ride_sequence(int unsigned samples, bit drain);
      logic [31:0] stamp;
      logic [11:0] watts;
      int unsigned pick, k;
      send_request(OP_START, $urandom, 12'($urandom));
      stamp = $urandom;
      for (int i = 0; i < samples; i++) begin
         watts = $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(0, 400));
         send_request(OP_SAMPLE, stamp, watts);
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            stamp += $urandom_range(0, tracker.interval + 100);
         end else if (pick < 95) begin
            // a few missing intervals
            k = $urandom_range(1, 16);
            stamp += 32'(tracker.interval) * k + 101 + $urandom_range(0, tracker.interval);
         end else begin
            stamp -= $urandom_range(1, 5000);
         end
      end
      if (drain)
         send_request(OP_FINISH, stamp, 12'($urandom));
   endtask

   initial begin : response_side
      int unsigned hold;
      wait (out_of_reset);
      forever begin
         hold = $urandom_range(0, rcv_max_gap);
         if (hold_request) begin
            hold += LONG_HOLD;
            hold_request = 1'b0;
         end
         @(negedge clock);
         if (hold != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         tracker.check_response(rsp_bus.score_q16, rsp_bus.average_power_q16,
                                rsp_bus.saturated);
      end
   end

   initial begin : request_side
      int unsigned phase_goal;
      tracker = new;
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.operation      = OP_START;
      req_bus.sample_time_ms = '0;
      req_bus.sample_watts   = '0;
      rsp_bus.ready          = 1'b0;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      out_of_reset = 1'b1;

      // directed: reset settings
      snd_max_gap = 3;
      rcv_max_gap = 3;
      send_request(OP_START,  32'd0, 12'd0);
      send_request(OP_SAMPLE, 32'd0, 12'hFFF);
      send_request(OP_SAMPLE, 32'd1000, 12'd0);
      send_request(OP_SAMPLE, 32'd2000, 12'hFFF);
      send_request(OP_SAMPLE, 32'd9000, 12'd300);    // six missing intervals
      send_request(OP_SAMPLE, 32'd5000, 12'd100);    // time runs backwards
      send_request(OP_UNUSED, 32'hFFFF_FFFF, 12'hFFF);
      send_request(OP_FINISH, 32'd0, 12'd0);
      send_request(OP_SAMPLE, 32'hFFFF_F000, 12'd2000);
      send_request(OP_FINISH, 32'd0, 12'd0);         // tail carries time past wrap
      send_request(OP_START,  32'hFFFF_FFFF, 12'hFFF);
      end_phase();

      // slowest decay, heaviest weights: average and score both clip, fill cap hit
      csr_write(REG_INTERVAL,   32'd60000);
      csr_write(REG_DECAY,      32'hFFFF);
      csr_write(REG_NEW_WEIGHT, 32'hFFFF);
      csr_write(REG_POINTS,     32'hFF_FFFF);
      csr_write(REG_INV_THRESH, 32'hFF_FFFF);
      send_request(OP_SAMPLE, 32'd0, 12'hFFF);
      send_request(OP_SAMPLE, 32'd60000, 12'hFFF);
      send_request(OP_FINISH, 32'd0, 12'd0);
      send_request(OP_SAMPLE, 32'hFFFF_FFFF, 12'hFFF);
      send_request(OP_START,  32'd0, 12'd0);
      end_phase();

      // zero interval and zero reciprocal
      csr_write(REG_INTERVAL,   32'd0);
      csr_write(REG_DECAY,      32'd63015);
      csr_write(REG_NEW_WEIGHT, 32'd2521);
      csr_write(REG_POINTS,     32'd1820);
      csr_write(REG_INV_THRESH, 32'd0);
      send_request(OP_SAMPLE, 32'd0, 12'hFFF);
      send_request(OP_SAMPLE, 32'd5000, 12'd1000);
      send_request(OP_FINISH, 32'd0, 12'd0);
      end_phase();

      csr_write(REG_INTERVAL,   32'd1);
      csr_write(REG_DECAY,      32'd0);
      csr_write(REG_NEW_WEIGHT, 32'd0);
      csr_write(REG_POINTS,     32'd1);
      csr_write(REG_INV_THRESH, 32'd1);
      send_request(OP_SAMPLE, 32'd1, 12'hFFF);
      send_request(OP_SAMPLE, 32'd700, 12'd12);
      send_request(OP_FINISH, 32'd0, 12'd0);
      send_request(OP_START,  32'd0, 12'd0);
      end_phase();

      // random rides under random settings
      for (int phase = 0; phase < 5; phase++) begin
         csr_write(REG_INTERVAL,   pick_setting(1000, 1, 60000));
         csr_write(REG_DECAY,      pick_setting(63015, 0, 16'hFFFF));
         csr_write(REG_NEW_WEIGHT, pick_setting(2521, 0, 16'hFFFF));
         csr_write(REG_POINTS,     pick_setting(1820, 0, 24'hFF_FFFF));
         csr_write(REG_INV_THRESH, pick_setting(67109, 1, 24'hFF_FFFF));
         snd_max_gap = pick_setting(0, 0, 10);
         rcv_max_gap = pick_setting(0, 0, 10);
         if (phase == 0) begin
            // receiver stalls long enough for the block to back up
            snd_max_gap  = 0;
            hold_request = 1'b1;
         end
         phase_goal = requests_sent + 165;
         while (requests_sent < phase_goal) begin
            if ($urandom_range(0, 9) == 0)
               send_request(2'($urandom), $urandom, 12'($urandom));
            else
               ride_sequence($urandom_range(5, 40), $urandom_range(0, 2) == 0);
         end
         end_phase();
      end

      repeat (100) @(posedge clock);
      if (tracker.failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
